### rtl/core/fpet_pkg.sv
// Shared types and constants for the FAT12 packed entry table.
// Used by fpet_ctrl, fpet_dpath and fat12_packed_entry_table_unit; depends on nothing.
package fpet_pkg;

	// operation codes carried in the opcode field
	localparam logic [2:0] OP_READ_ENTRY  = 3'd0;
	localparam logic [2:0] OP_WRITE_ENTRY = 3'd1;
	localparam logic [2:0] OP_ALLOCATE    = 3'd2;
	localparam logic [2:0] OP_LOAD_BYTE   = 3'd3;
	localparam logic [2:0] OP_READ_BYTE   = 3'd4;

	localparam logic [11:0] ENTRY_NONE         = 12'hFFF;
	localparam logic [11:0] FIRST_DATA_CLUSTER = 12'd2;
	localparam logic [11:0] SCAN_END_RESET     = 12'd2848;

	// width of a byte position derived from a cluster number (c + c/2)
	localparam int POS_W = 13;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [11:0] cluster;
		logic [11:0] entry_value;
		logic [12:0] byte_addr;
		logic [7:0]  byte_data;
	} op_word_t;

	typedef struct packed {
		logic [11:0] entry_out;
		logic [7:0]  byte_out;
		logic        out_of_range;
	} res_word_t;

	typedef enum logic [1:0] {
		ADDR_POS,
		ADDR_POS1,
		ADDR_BYTE
	} addr_sel_t;

	typedef enum logic [1:0] {
		WD_LO,
		WD_HI,
		WD_BYTE
	} wdata_sel_t;

	typedef struct packed {
		logic       load_op;
		logic       mem_rd;
		logic       mem_wr;
		addr_sel_t  addr_sel;
		wdata_sel_t wdata_sel;
		logic       cap_lo;
		logic       next_cluster;
		logic       res_ld;
	} cmd_t;

	typedef struct packed {
		logic pos_oor;
		logic byte_oor;
		logic scan_done;
		logic entry_zero;
	} status_t;

endpackage

### rtl/core/fat12_packed_entry_table_unit.sv
// Top level of the FAT12 packed entry table: controller, datapath, config port.
// Depends on fpet_pkg, fpet_ctrl and fpet_dpath.
//
// Usage:
//   op channel  (op_valid / op_stall / op_word): one operation word per item.
//   res channel (res_valid / res_stall / res_word): exactly one result word
//   per operation, in order. cfg channel (cfg_valid / cfg_ready / cfg_data)
//   writes alloc_scan_end; write it only while the block is idle.
// Store accesses per operation, on the single-port store with its read registered:
//   load byte, read byte ............ one access (none if beyond the table); unused codes none
//   read entry ...................... two reads (none if beyond the table)
//   write entry ..................... two reads, then two writes (none if beyond the table)
//   allocate ........................ two reads per cluster examined, until a free entry
//                                     is found or the scan runs out
// One operation is in flight at a time. A new word can be taken once the previous
// result is in the output register, even while the receiver still stalls that
// result. A stalled result holds until taken, and the next result waits behind it.
// Reset sets alloc_scan_end to 2848 and clears all control state; the table
// itself is undefined until loaded, so load it before any entry access.
module fat12_packed_entry_table_unit #(
	parameter int TABLE_BYTES = 4608
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                op_valid,
	output logic                op_stall,
	input  fpet_pkg::op_word_t  op_word,
	output logic                res_valid,
	input  logic                res_stall,
	output fpet_pkg::res_word_t res_word,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [11:0]         cfg_data
);

	fpet_pkg::cmd_t    cmd;
	fpet_pkg::status_t status;
	logic              cfg_ready_q;

	// hold off config writes until reset has been released
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_ready_q <= 1'b0;
		end else begin
			cfg_ready_q <= 1'b1;
		end
	end

	assign cfg_ready = cfg_ready_q;

	fpet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_opcode (op_word.opcode),
		.op_stall  (op_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.status    (status),
		.cmd       (cmd)
	);

	fpet_dpath #(
		.TABLE_BYTES (TABLE_BYTES)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready_q),
		.cfg_data (cfg_data),
		.op_word  (op_word),
		.cmd      (cmd),
		.status   (status),
		.res_word (res_word)
	);

	// busy right after taking a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid && !op_stall |=> op_stall)
		else $error("op channel not stalled after accepting a word");

	// a fresh result only appears at the end of an operation
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(op_stall))
		else $error("result raised while no operation was in flight");

	// no store write while the block is idle
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		!op_stall |-> !cmd.mem_wr && !cmd.res_ld)
		else $error("store or result written while idle");

endmodule

### rtl/core/fpet_dpath.sv
// Datapath of the FAT12 packed entry table: byte store, operand and result registers.
// Depends on fpet_pkg; driven by the command word from fpet_ctrl.
module fpet_dpath #(
	parameter int TABLE_BYTES = 4608
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [11:0]         cfg_data,
	input  fpet_pkg::op_word_t  op_word,
	input  fpet_pkg::cmd_t      cmd,
	output fpet_pkg::status_t   status,
	output fpet_pkg::res_word_t res_word
);

	localparam int AW = $clog2(TABLE_BYTES);
	localparam logic [fpet_pkg::POS_W:0] LAST_POS = (fpet_pkg::POS_W + 1)'(TABLE_BYTES - 1);
	localparam logic [fpet_pkg::POS_W:0] BYTE_LIM = (fpet_pkg::POS_W + 1)'(TABLE_BYTES);

	logic [7:0] mem [TABLE_BYTES];

	fpet_pkg::op_word_t     op_q;
	fpet_pkg::res_word_t    res_q;
	logic [11:0]            cur_q;
	logic [11:0]            scan_end_q;
	logic [7:0]             lo_q;
	logic [7:0]             rdata_q;
	logic [fpet_pkg::POS_W-1:0] pos;
	logic [fpet_pkg::POS_W-1:0] pos1;
	logic [AW-1:0]          addr;
	logic [7:0]             wdata;
	logic [11:0]            entry;
	logic [11:0]            alloc_res;
	fpet_pkg::res_word_t    res_d;
	logic                   odd;

	assign odd  = cur_q[0];
	assign pos  = {1'b0, cur_q} + fpet_pkg::POS_W'(cur_q[11:1]);
	assign pos1 = pos + fpet_pkg::POS_W'(1);

	assign status.pos_oor    = {1'b0, pos} >= LAST_POS;
	assign status.byte_oor   = {1'b0, op_q.byte_addr} >= BYTE_LIM;
	assign status.scan_done  = cur_q >= scan_end_q;
	assign status.entry_zero = entry == 12'd0;

	// low byte sits in lo_q, high byte in the last read word
	assign entry = odd ? {rdata_q, lo_q[7:4]} : {rdata_q[3:0], lo_q};
	assign alloc_res = (status.scan_done || status.pos_oor) ? 12'd0 : cur_q;

	always_comb begin
		unique case (cmd.addr_sel)
			fpet_pkg::ADDR_POS:  addr = pos[AW-1:0];
			fpet_pkg::ADDR_POS1: addr = pos1[AW-1:0];
			fpet_pkg::ADDR_BYTE: addr = op_q.byte_addr[AW-1:0];
			default:             addr = pos[AW-1:0];
		endcase
	end

	// merge the new entry with the neighbouring nibble
	always_comb begin
		unique case (cmd.wdata_sel)
			fpet_pkg::WD_LO:   wdata = odd ? {op_q.entry_value[3:0], lo_q[3:0]}
			                               : op_q.entry_value[7:0];
			fpet_pkg::WD_HI:   wdata = odd ? op_q.entry_value[11:4]
			                               : {rdata_q[7:4], op_q.entry_value[11:8]};
			fpet_pkg::WD_BYTE: wdata = op_q.byte_data;
			default:           wdata = op_q.byte_data;
		endcase
	end

	always_comb begin
		res_d = '0;
		case (op_q.opcode)
			fpet_pkg::OP_READ_ENTRY: begin
				res_d.entry_out    = status.pos_oor ? fpet_pkg::ENTRY_NONE : entry;
				res_d.out_of_range = status.pos_oor;
			end
			fpet_pkg::OP_WRITE_ENTRY: res_d.out_of_range = status.pos_oor;
			fpet_pkg::OP_ALLOCATE:    res_d.entry_out = alloc_res;
			fpet_pkg::OP_LOAD_BYTE:   res_d.out_of_range = status.byte_oor;
			fpet_pkg::OP_READ_BYTE: begin
				res_d.byte_out     = status.byte_oor ? 8'd0 : rdata_q;
				res_d.out_of_range = status.byte_oor;
			end
			default: res_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			mem[addr] <= wdata;
		end
		if (cmd.mem_rd) begin
			rdata_q <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_op) begin
			op_q  <= op_word;
			cur_q <= (op_word.opcode == fpet_pkg::OP_ALLOCATE) ? fpet_pkg::FIRST_DATA_CLUSTER
			                                                   : op_word.cluster;
		end else if (cmd.next_cluster) begin
			cur_q <= cur_q + 12'd1;
		end
		if (cmd.cap_lo) begin
			lo_q <= rdata_q;
		end
		if (cmd.res_ld) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_end_q <= fpet_pkg::SCAN_END_RESET;
		end else if (cfg_we) begin
			scan_end_q <= cfg_data;
		end
	end

	assign res_word = res_q;

endmodule

### rtl/core/fpet_ctrl.sv
// Controller of the FAT12 packed entry table: sequences store accesses per operation.
// Depends on fpet_pkg; drives fpet_dpath through the command word.
module fpet_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	input  logic [2:0]        op_opcode,
	output logic              op_stall,
	output logic              res_valid,
	input  logic              res_stall,
	input  fpet_pkg::status_t status,
	output fpet_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ERD0,
		S_ERD1,
		S_EWR0,
		S_EWR1,
		S_EWR2,
		S_EWR3,
		S_ALC0,
		S_ALC1,
		S_ALC2,
		S_LDB,
		S_RDB,
		S_FIN
	} state_t;

	state_t state_q, state_d;
	logic   stall_q;
	logic   res_valid_q;
	logic   accept;
	logic   res_free;

	assign accept   = op_valid && !stall_q;
	assign res_free = !res_valid_q || !res_stall;

	always_comb begin
		cmd = '0;
		cmd.addr_sel  = fpet_pkg::ADDR_POS;
		cmd.wdata_sel = fpet_pkg::WD_BYTE;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load_op = 1'b1;
					unique case (op_opcode)
						fpet_pkg::OP_READ_ENTRY:  state_d = S_ERD0;
						fpet_pkg::OP_WRITE_ENTRY: state_d = S_EWR0;
						fpet_pkg::OP_ALLOCATE:    state_d = S_ALC0;
						fpet_pkg::OP_LOAD_BYTE:   state_d = S_LDB;
						fpet_pkg::OP_READ_BYTE:   state_d = S_RDB;
						default:                  state_d = S_FIN;
					endcase
				end
			end
			S_ERD0: begin
				if (status.pos_oor) begin
					state_d = S_FIN;
				end else begin
					cmd.mem_rd = 1'b1;
					state_d = S_ERD1;
				end
			end
			S_ERD1: begin
				cmd.mem_rd   = 1'b1;
				cmd.addr_sel = fpet_pkg::ADDR_POS1;
				cmd.cap_lo   = 1'b1;
				state_d = S_FIN;
			end
			S_EWR0: begin
				if (status.pos_oor) begin
					state_d = S_FIN;
				end else begin
					cmd.mem_rd = 1'b1;
					state_d = S_EWR1;
				end
			end
			S_EWR1: begin
				cmd.mem_rd   = 1'b1;
				cmd.addr_sel = fpet_pkg::ADDR_POS1;
				cmd.cap_lo   = 1'b1;
				state_d = S_EWR2;
			end
			S_EWR2: begin
				cmd.mem_wr    = 1'b1;
				cmd.wdata_sel = fpet_pkg::WD_LO;
				state_d = S_EWR3;
			end
			S_EWR3: begin
				cmd.mem_wr    = 1'b1;
				cmd.addr_sel  = fpet_pkg::ADDR_POS1;
				cmd.wdata_sel = fpet_pkg::WD_HI;
				state_d = S_FIN;
			end
			S_ALC0: begin
				// stop at the scan bound or where entries leave the table
				if (status.scan_done || status.pos_oor) begin
					state_d = S_FIN;
				end else begin
					cmd.mem_rd = 1'b1;
					state_d = S_ALC1;
				end
			end
			S_ALC1: begin
				cmd.mem_rd   = 1'b1;
				cmd.addr_sel = fpet_pkg::ADDR_POS1;
				cmd.cap_lo   = 1'b1;
				state_d = S_ALC2;
			end
			S_ALC2: begin
				if (status.entry_zero) begin
					state_d = S_FIN;
				end else begin
					cmd.next_cluster = 1'b1;
					state_d = S_ALC0;
				end
			end
			S_LDB: begin
				cmd.mem_wr   = !status.byte_oor;
				cmd.addr_sel = fpet_pkg::ADDR_BYTE;
				state_d = S_FIN;
			end
			S_RDB: begin
				cmd.mem_rd   = !status.byte_oor;
				cmd.addr_sel = fpet_pkg::ADDR_BYTE;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (res_free) begin
					cmd.res_ld = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			stall_q     <= 1'b1;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				stall_q <= 1'b1;
			end else if (state_d == S_IDLE) begin
				stall_q <= 1'b0;
			end
			if (cmd.res_ld) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign op_stall  = stall_q;
	assign res_valid = res_valid_q;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for fat12_packed_entry_table_unit: a bit-level model of the packed
// table predicts every result word, and a checker compares them in order. Depends on fpet_pkg.
module tb_top;

	localparam int TABLE_BYTES = 4608;
	// Only the low clusters and the last few bytes are loaded; every access stays there or
	// lies beyond the table.
	localparam int FILL_CLUSTERS     = 512;
	localparam int FILL_BYTES        = FILL_CLUSTERS * 3 / 2;
	localparam int TAIL_BYTES        = 8;
	localparam int FIRST_OOR_CLUSTER = 3072;
	// Even if every allocate ran the whole scan range under heavy stalls, the run would stay
	// well below this.
	localparam int CYCLE_LIMIT = 4000000;
	localparam int HOLD_CYCLES = 300;
	localparam int REPORT_CAP  = 200;
	localparam logic [2:0] OP_LAST_CODE = 3'd7;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                op_valid  = 1'b0;
	logic                op_stall;
	fpet_pkg::op_word_t  op_word   = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	fpet_pkg::res_word_t res_word;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [11:0]         cfg_data  = '0;

	// mirror of the table, advanced once per accepted word, and of the scan bound
	logic [7:0]          fat_mirror [TABLE_BYTES];
	logic [11:0]         scan_end_mirror = fpet_pkg::SCAN_END_RESET;
	fpet_pkg::res_word_t pending_results [$];

	int errors        = 0;
	int items_sent    = 0;
	int cycles        = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_starts   = 0;
	int hold_seen     = 0;
	int hold_left     = 0;

	// clusters handed out by allocate, and the tail of the chain being built
	int          owned_clusters [$];
	logic [11:0] chain_tail = '0;
	logic        chain_live = 1'b0;

	fat12_packed_entry_table_unit #(
		.TABLE_BYTES(TABLE_BYTES)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_stall (op_stall),
		.op_word  (op_word),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_word (res_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	// guard against a hung block
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// ---------------------------------------------------------------- table mirror

	// Fetch the 12-bit entry of cluster c; entries whose second byte falls off the table
	// read as the end marker and flag out of range.
	function automatic logic [11:0] entry_fetch(input logic [11:0] c, output logic oor);
		int          p;
		logic [15:0] raw;
		p = int'(c) + int'(c >> 1);
		if (p + 1 >= TABLE_BYTES) begin
			oor = 1'b1;
			return fpet_pkg::ENTRY_NONE;
		end
		oor = 1'b0;
		raw = {fat_mirror[p + 1], fat_mirror[p]};
		return c[0] ? raw[15:4] : raw[11:0];
	endfunction

	// Store v into cluster c, keeping the nibble shared with the neighbouring entry.
	function automatic logic entry_store(input logic [11:0] c, input logic [11:0] v);
		int p;
		p = int'(c) + int'(c >> 1);
		if (p + 1 >= TABLE_BYTES)
			return 1'b0;
		if (c[0]) begin
			fat_mirror[p]     = {v[3:0], fat_mirror[p][3:0]};
			fat_mirror[p + 1] = v[11:4];
		end else begin
			fat_mirror[p]     = v[7:0];
			fat_mirror[p + 1] = {fat_mirror[p + 1][7:4], v[11:8]};
		end
		return 1'b1;
	endfunction

	// First free cluster from the first data cluster up to the scan bound, 0 if none.
	function automatic logic [11:0] find_free_cluster();
		logic        oor;
		logic [11:0] e;
		for (int c = fpet_pkg::FIRST_DATA_CLUSTER; c < scan_end_mirror; c++) begin
			e = entry_fetch(12'(c), oor);
			if (e == 12'd0 && !oor)
				return 12'(c);
		end
		return 12'd0;
	endfunction

	// Expected result word of one operation word; updates the mirror as the block would.
	function automatic fpet_pkg::res_word_t table_outcome(input fpet_pkg::op_word_t w);
		fpet_pkg::res_word_t r;
		logic                oor;
		r = '0;
		case (w.opcode)
			fpet_pkg::OP_READ_ENTRY: begin
				r.entry_out    = entry_fetch(w.cluster, oor);
				r.out_of_range = oor;
			end
			fpet_pkg::OP_WRITE_ENTRY: begin
				r.out_of_range = !entry_store(w.cluster, w.entry_value);
			end
			fpet_pkg::OP_ALLOCATE: begin
				r.entry_out = find_free_cluster();
			end
			fpet_pkg::OP_LOAD_BYTE: begin
				if (w.byte_addr < TABLE_BYTES)
					fat_mirror[w.byte_addr] = w.byte_data;
				else
					r.out_of_range = 1'b1;
			end
			fpet_pkg::OP_READ_BYTE: begin
				if (w.byte_addr < TABLE_BYTES)
					r.byte_out = fat_mirror[w.byte_addr];
				else
					r.out_of_range = 1'b1;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what, input int got, input int want);
		if (errors < REPORT_CAP)
			$display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
		errors++;
	endtask

	task automatic check_result(input fpet_pkg::res_word_t got);
		fpet_pkg::res_word_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("result word with nothing pending", int'(got), 0);
			return;
		end
		want = pending_results.pop_front();
		if (got.entry_out !== want.entry_out)
			report_mismatch("entry_out", got.entry_out, want.entry_out);
		if (got.byte_out !== want.byte_out)
			report_mismatch("byte_out", got.byte_out, want.byte_out);
		if (got.out_of_range !== want.out_of_range)
			report_mismatch("out_of_range", got.out_of_range, want.out_of_range);
	endtask

	// Receiver: take a word whenever valid meets no stall, then choose the next stall.
	// A hold-off request keeps stall high for a long stretch, counted here.
	always @(posedge clk) begin
		if (res_valid && !res_stall)
			check_result(res_word);
		if (hold_seen != hold_starts) begin
			hold_seen <= hold_starts;
			hold_left <= HOLD_CYCLES;
			res_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// ---------------------------------------------------------------- driving

	// Mostly the loaded low clusters, where allocation and chains live; sometimes past
	// the end of the table.
	function automatic logic [11:0] pick_cluster();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 9)
			return 12'($urandom_range(0, FILL_CLUSTERS - 1));
		return 12'($urandom_range(FIRST_OOR_CLUSTER, 4095));
	endfunction

	// Mostly a loaded byte; sometimes an address past the end of the table.
	function automatic logic [12:0] pick_byte_addr();
		if ($urandom_range(0, 4) != 0)
			return 13'($urandom_range(0, FILL_BYTES - 1));
		return 13'($urandom_range(TABLE_BYTES, 8191));
	endfunction

	function automatic fpet_pkg::op_word_t random_word();
		fpet_pkg::op_word_t w;
		w.opcode      = 3'($urandom_range(0, OP_LAST_CODE));
		w.cluster     = pick_cluster();
		w.entry_value = 12'($urandom_range(0, 4095));
		w.byte_addr   = pick_byte_addr();
		w.byte_data   = 8'($urandom_range(0, 255));
		return w;
	endfunction

	// Offer one operation word, hold it until accepted, and log its expected result.
	// Valid stays high straight into the next word unless this one starts with a gap.
	task automatic send_op(input fpet_pkg::op_word_t w, output fpet_pkg::res_word_t r);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			op_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		op_valid <= 1'b1;
		op_word  <= w;
		@(posedge clk);
		while (op_stall)
			@(posedge clk);
		r = table_outcome(w);
		pending_results.push_back(r);
		items_sent++;
	endtask

	task automatic do_entry_op(input logic [2:0] code, input logic [11:0] c,
			input logic [11:0] v, output fpet_pkg::res_word_t r);
		fpet_pkg::op_word_t w;
		w             = random_word();
		w.opcode      = code;
		w.cluster     = c;
		w.entry_value = v;
		send_op(w, r);
	endtask

	task automatic do_byte_op(input logic [2:0] code, input logic [12:0] a,
			input logic [7:0] d, output fpet_pkg::res_word_t r);
		fpet_pkg::op_word_t w;
		w           = random_word();
		w.opcode    = code;
		w.byte_addr = a;
		w.byte_data = d;
		send_op(w, r);
	endtask

	// Drop valid and wait until every pending result word has come back.
	task automatic settle_block();
		op_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the scan bound; call only once the block has settled.
	task automatic write_scan_end(input logic [11:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		scan_end_mirror = v;
	endtask

	// ---------------------------------------------------------------- tests

	// Load the bytes of the low clusters and the last bytes of the table before any
	// entry access; zero bytes are common so that allocation finds free clusters early.
	task automatic test_table_fill();
		fpet_pkg::res_word_t r;
		logic [7:0]          d;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int a = 0; a < FILL_BYTES; a++) begin
			d = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
			do_byte_op(fpet_pkg::OP_LOAD_BYTE, 13'(a), d, r);
		end
		for (int a = TABLE_BYTES - TAIL_BYTES; a < TABLE_BYTES; a++) begin
			d = 8'($urandom_range(0, 255));
			do_byte_op(fpet_pkg::OP_LOAD_BYTE, 13'(a), d, r);
		end
	endtask

	// Shared nibble between an even and odd pair, the last entry inside the table,
	// and entries beyond it.
	task automatic test_entry_edges();
		fpet_pkg::res_word_t r;
		do_entry_op(fpet_pkg::OP_WRITE_ENTRY, 12'd0, fpet_pkg::ENTRY_NONE, r);
		do_entry_op(fpet_pkg::OP_WRITE_ENTRY, 12'd1, 12'd0, r);
		do_entry_op(fpet_pkg::OP_READ_ENTRY, 12'd0, 12'd0, r);
		do_entry_op(fpet_pkg::OP_READ_ENTRY, 12'd1, 12'd0, r);
		do_entry_op(fpet_pkg::OP_WRITE_ENTRY, 12'd1, fpet_pkg::ENTRY_NONE, r);
		do_entry_op(fpet_pkg::OP_WRITE_ENTRY, 12'd0, 12'd0, r);
		do_entry_op(fpet_pkg::OP_READ_ENTRY, 12'd1, 12'd0, r);
		do_entry_op(fpet_pkg::OP_READ_ENTRY, 12'd0, 12'd0, r);
		do_entry_op(fpet_pkg::OP_WRITE_ENTRY, 12'd3071, 12'hA5C, r);
		do_entry_op(fpet_pkg::OP_READ_ENTRY, 12'd3071, 12'd0, r);
		do_entry_op(fpet_pkg::OP_READ_ENTRY, 12'd3072, 12'd0, r);
		do_entry_op(fpet_pkg::OP_WRITE_ENTRY, 12'd3072, 12'h123, r);
		do_entry_op(fpet_pkg::OP_READ_ENTRY, 12'd4095, 12'd0, r);
		do_entry_op(fpet_pkg::OP_WRITE_ENTRY, 12'd4095, fpet_pkg::ENTRY_NONE, r);
	endtask

	// First and last byte of the table, then addresses just past it and at the top of the field.
	task automatic test_byte_edges();
		fpet_pkg::res_word_t r;
		do_byte_op(fpet_pkg::OP_READ_BYTE, 13'd0, 8'd0, r);
		do_byte_op(fpet_pkg::OP_READ_BYTE, 13'(TABLE_BYTES - 1), 8'd0, r);
		do_byte_op(fpet_pkg::OP_LOAD_BYTE, 13'(TABLE_BYTES), 8'hFF, r);
		do_byte_op(fpet_pkg::OP_READ_BYTE, 13'(TABLE_BYTES), 8'd0, r);
		do_byte_op(fpet_pkg::OP_LOAD_BYTE, 13'h1FFF, 8'hFF, r);
		do_byte_op(fpet_pkg::OP_READ_BYTE, 13'h1FFF, 8'd0, r);
	endtask

	task automatic test_unused_codes();
		fpet_pkg::res_word_t r;
		fpet_pkg::op_word_t  w;
		for (int k = fpet_pkg::OP_READ_BYTE + 1; k <= OP_LAST_CODE; k++) begin
			w        = random_word();
			w.opcode = 3'(k);
			send_op(w, r);
		end
	endtask

	// Narrowest scan with its only cluster taken, then freed; then the widest scan.
	task automatic test_alloc_bounds();
		fpet_pkg::res_word_t r;
		settle_block();
		write_scan_end(12'd3);
		do_entry_op(fpet_pkg::OP_WRITE_ENTRY, fpet_pkg::FIRST_DATA_CLUSTER,
			fpet_pkg::ENTRY_NONE, r);
		do_entry_op(fpet_pkg::OP_ALLOCATE, 12'd0, 12'd0, r);
		do_entry_op(fpet_pkg::OP_WRITE_ENTRY, fpet_pkg::FIRST_DATA_CLUSTER, 12'd0, r);
		do_entry_op(fpet_pkg::OP_ALLOCATE, 12'd0, 12'd0, r);
		settle_block();
		write_scan_end(12'd3072);
		do_entry_op(fpet_pkg::OP_ALLOCATE, 12'd0, 12'd0, r);
	endtask

	// Chain building and freeing as a file system would do it, with random
	// entry and byte traffic and some plain noise mixed in.
	task automatic test_random_traffic(input int s_pct, input int r_pct,
			input logic [11:0] scan_end, input int count);
		fpet_pkg::res_word_t r;
		fpet_pkg::op_word_t  w;
		logic [11:0]         c;
		logic [11:0]         v;
		int                  goal;
		int                  kind;
		settle_block();
		write_scan_end(scan_end);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		goal = items_sent + count;
		while (items_sent < goal) begin
			kind = $urandom_range(0, 99);
			if (kind < 30 || (kind < 45 && owned_clusters.size() == 0)) begin
				// allocate, mark end of chain, link the old tail to it, read back
				do_entry_op(fpet_pkg::OP_ALLOCATE, pick_cluster(),
					12'($urandom_range(0, 4095)), r);
				c = r.entry_out;
				if (c != 12'd0) begin
					do_entry_op(fpet_pkg::OP_WRITE_ENTRY, c,
						12'($urandom_range(12'hFF8, 12'hFFF)), r);
					if (chain_live)
						do_entry_op(fpet_pkg::OP_WRITE_ENTRY, chain_tail, c, r);
					do_entry_op(fpet_pkg::OP_READ_ENTRY, c, 12'd0, r);
					owned_clusters.push_back(int'(c));
					chain_tail = c;
				end
				chain_live = (c != 12'd0) && ($urandom_range(0, 7) != 0);
			end else if (kind < 45) begin
				// release the oldest allocated cluster and look at it and its partner
				c = 12'(owned_clusters.pop_front());
				do_entry_op(fpet_pkg::OP_WRITE_ENTRY, c, 12'd0, r);
				do_entry_op(fpet_pkg::OP_READ_ENTRY, c, 12'd0, r);
				do_entry_op(fpet_pkg::OP_READ_ENTRY, c ^ 12'd1, 12'd0, r);
			end else if (kind < 65) begin
				c = pick_cluster();
				v = ($urandom_range(0, 2) == 0) ? 12'd0 : 12'($urandom_range(0, 4095));
				do_entry_op(fpet_pkg::OP_WRITE_ENTRY, c, v, r);
				do_entry_op(fpet_pkg::OP_READ_ENTRY, c, 12'd0, r);
				do_entry_op(fpet_pkg::OP_READ_ENTRY, c ^ 12'd1, 12'd0, r);
			end else if (kind < 77) begin
				do_entry_op(fpet_pkg::OP_READ_ENTRY, pick_cluster(),
					12'($urandom_range(0, 4095)), r);
			end else if (kind < 92) begin
				w = random_word();
				w.opcode = (kind < 85) ? fpet_pkg::OP_READ_BYTE : fpet_pkg::OP_LOAD_BYTE;
				send_op(w, r);
			end else if (kind < 95) begin
				w = random_word();
				w.opcode = 3'($urandom_range(fpet_pkg::OP_READ_BYTE + 1, OP_LAST_CODE));
				send_op(w, r);
			end else begin
				send_op(random_word(), r);
			end
		end
	endtask

	// Hold the receiver off for a long stretch while words keep coming, so that the
	// output register fills and the input stalls.
	task automatic test_backpressure();
		fpet_pkg::res_word_t r;
		settle_block();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_starts++;
		repeat (12)
			do_entry_op(fpet_pkg::OP_READ_ENTRY, pick_cluster(), 12'd0, r);
		settle_block();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_table_fill();
		test_entry_edges();
		test_byte_edges();
		test_unused_codes();
		test_alloc_bounds();
		test_random_traffic(15, 72, 12'($urandom_range(64, 400)), 360);
		test_random_traffic(72, 15, 12'(FILL_CLUSTERS), 360);
		test_random_traffic(0, 0, 12'($urandom_range(3, FILL_CLUSTERS)), 220);
		test_backpressure();
		test_random_traffic(0, 0, 12'(FILL_CLUSTERS), 140);

		settle_block();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
